>>> rtl/core/slpq_pkg.sv
// Shared types and codes for the sorted-list priority queue.
package slpq_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned STATUS_W = 2;

  // Action codes; the decoder looks at bit 1 first, so the unused code acts as remove largest.
  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT  = 2'd0,
    ACT_POP_MIN = 2'd1,
    ACT_POP_MAX = 2'd2,
    ACT_SPARE   = 2'd3
  } action_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic {
    SEQ_IDLE,
    SEQ_SEEK
  } seq_state_t;

  // Command broadcast to every cell in the chain.
  typedef struct packed {
    logic                     ins;
    logic                     pop_min;
    logic                     seek;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

>>> rtl/core/slpq_if.sv
// Valid/ready channel interfaces for the input and result streams.
interface slpq_in_if;
  import slpq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ACTION_W-1:0]      action;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface slpq_out_if;
  import slpq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic [STATUS_W-1:0]      status;

  modport source (output valid, output result_value, output status, input ready);
  modport sink   (input valid, input result_value, input status, output ready);
endinterface

>>> rtl/core/slpq_cell.sv
// One storage cell of the sorted chain: holds an entry and a tail-carry register.
module slpq_cell (
  input  logic                              clk,
  input  slpq_pkg::cell_ctrl_t              ctrl,
  input  logic                              occ,
  input  logic                              left_le,
  input  logic signed [slpq_pkg::DATA_W-1:0] left_entry,
  input  logic                              right_occ,
  input  logic signed [slpq_pkg::DATA_W-1:0] right_entry,
  input  logic signed [slpq_pkg::DATA_W-1:0] right_tail,
  output logic                              le,
  output logic signed [slpq_pkg::DATA_W-1:0] entry,
  output logic signed [slpq_pkg::DATA_W-1:0] tail
);
  import slpq_pkg::*;

  logic signed [DATA_W-1:0] entry_r, entry_nxt;
  logic signed [DATA_W-1:0] tail_r, tail_nxt;

  // The entries that are not above the new value form a prefix of the chain.
  assign le = occ && (entry_r <= ctrl.value);

  // Insert opens a gap at the first larger entry; removing the smallest shifts all down.
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins) begin
      if (!le) begin
        entry_nxt = left_le ? ctrl.value : left_entry;
      end
    end else if (ctrl.pop_min) begin
      entry_nxt = right_entry;
    end
  end

  // The last occupied cell launches its entry, which then travels one cell per cycle to the head.
  always_comb begin
    tail_nxt = tail_r;
    if (ctrl.seek) begin
      tail_nxt = (occ && !right_occ) ? entry_r : right_tail;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    tail_r  <= tail_nxt;
  end

  assign entry = entry_r;
  assign tail  = tail_r;

endmodule

>>> rtl/core/sorted_list_priority_queue.sv
// Top level of the sorted-list double-ended priority queue built as a chain of cells.
// Insert and remove smallest update the chain at the transfer; a result is registered and
// visible the cycle after the transfer, and the next item may follow at once if the result is taken.
// Remove largest walks the last entry down the tail-carry chain to the head; from transfer
// to result no item is taken.
// Synchronous active-low reset empties the store; entry contents are not cleared.
module sorted_list_priority_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  slpq_in_if.sink   in_ch,
  slpq_out_if.source out_ch
);
  import slpq_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  seq_state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] seek_cnt_r, seek_cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_value_r, out_value_nxt;
  status_t                  out_status_r, out_status_nxt;

  logic out_free, in_ready, acc;
  logic is_ins, is_min, is_max, empty, full;
  logic load_out, pop_max;
  cell_ctrl_t ctrl;

  logic                     occ   [CAPACITY];
  logic                     le    [CAPACITY];
  logic signed [DATA_W-1:0] entry [CAPACITY];
  logic signed [DATA_W-1:0] tail  [CAPACITY];

  // Handshake and action decode.
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ready = (state_r == SEQ_IDLE) && out_free;
  assign acc      = in_ch.valid && in_ready;
  assign is_max   = in_ch.action[1];
  assign is_min   = !in_ch.action[1] && in_ch.action[0];
  assign is_ins   = !in_ch.action[1] && !in_ch.action[0];
  assign empty    = (count_r == '0);
  assign full     = (count_r == CNT_W'(CAPACITY));

  // Command broadcast to the cells.
  always_comb begin
    ctrl.ins     = acc && is_ins && !full;
    ctrl.pop_min = acc && is_min && !empty;
    ctrl.seek    = (state_r == SEQ_SEEK) && (seek_cnt_r != '0);
    ctrl.value   = in_ch.value;
  end

  // The chain of cells, smallest entry at the head.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     l_le;
    logic signed [DATA_W-1:0] l_entry;
    logic                     r_occ;
    logic signed [DATA_W-1:0] r_entry;
    logic signed [DATA_W-1:0] r_tail;

    assign occ[i] = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign l_le    = 1'b1;
      assign l_entry = ctrl.value;
    end else begin : g_body
      assign l_le    = le[i-1];
      assign l_entry = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign r_occ   = 1'b0;
      assign r_entry = '0;
      assign r_tail  = '0;
    end else begin : g_mid
      assign r_occ   = occ[i+1];
      assign r_entry = entry[i+1];
      assign r_tail  = tail[i+1];
    end

    slpq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (occ[i]),
      .left_le     (l_le),
      .left_entry  (l_entry),
      .right_occ   (r_occ),
      .right_entry (r_entry),
      .right_tail  (r_tail),
      .le          (le[i]),
      .entry       (entry[i]),
      .tail        (tail[i])
    );
  end

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SEQ_IDLE: begin
        if (acc && is_max && !empty) begin
          state_nxt = SEQ_SEEK;
        end
      end
      SEQ_SEEK: begin
        if ((seek_cnt_r == '0) && out_free) begin
          state_nxt = SEQ_IDLE;
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  // Sequencer outputs: result loading and the removal of the largest entry.
  always_comb begin
    load_out       = 1'b0;
    pop_max        = 1'b0;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    seek_cnt_nxt   = seek_cnt_r;
    unique case (state_r)
      SEQ_IDLE: begin
        seek_cnt_nxt = count_r;
        if (acc) begin
          if (is_ins) begin
            load_out       = 1'b1;
            out_value_nxt  = full ? '0 : in_ch.value;
            out_status_nxt = full ? STAT_FULL : STAT_OK;
          end else if (empty) begin
            load_out       = 1'b1;
            out_value_nxt  = '0;
            out_status_nxt = STAT_EMPTY;
          end else if (is_min) begin
            load_out       = 1'b1;
            out_value_nxt  = entry[0];
            out_status_nxt = STAT_OK;
          end
        end
      end
      SEQ_SEEK: begin
        if (seek_cnt_r != '0) begin
          seek_cnt_nxt = seek_cnt_r - 1'b1;
        end else if (out_free) begin
          load_out       = 1'b1;
          pop_max        = 1'b1;
          out_value_nxt  = tail[0];
          out_status_nxt = STAT_OK;
        end
      end
      default: ;
    endcase
  end

  // Fill count and result valid.
  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (ctrl.pop_min || pop_max) begin
      count_nxt = count_r - 1'b1;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SEQ_IDLE;
      count_r     <= '0;
      seek_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      seek_cnt_r  <= seek_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_value_r;
  assign out_ch.status       = out_status_r;

  // The fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  // While the largest entry is being fetched no new item is taken.
  a_seek_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SEQ_SEEK) |-> !in_ready)
    else $error("input taken during largest-entry fetch");

  // An accepted insert into a store with room grows the count by one.
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && is_ins && !full) |=> (count_r == $past(count_r) + 1'b1))
    else $error("insert did not grow the store");

  // A failed request carries a zero value.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != STAT_OK)) |-> (out_value_r == '0))
    else $error("non-zero value with failure status");

endmodule
